FILE: design/swmm_pkg.sv
// Shared types and constants for the sliding-window minimum/maximum block.
// Used by swmm_cell and sliding_window_min_max; depends on nothing.
`default_nettype none

package swmm_pkg;

  localparam int SAMPLE_W       = 32;
  localparam int CFG_W          = 7;
  localparam int WINDOW_MAX_DEF = 64;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  // Running extremes that travel down the chain of cells, one cell per cycle.
  typedef struct packed {
    logic    act;
    sample_t lo;
    sample_t hi;
  } token_t;

  localparam sample_t SAMPLE_POS_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam sample_t SAMPLE_NEG_MAX = {1'b1, {(SAMPLE_W-1){1'b0}}};

endpackage

`default_nettype wire

FILE: design/sliding_window_min_max.sv
// Sliding-window minimum and maximum over a signed sample stream.
// Slave channel s_*: one sample per item, restart flag in s_tuser[0].
// Master channel m_*: one result per item once the window is full,
//   m_tdata = {window_max, window_min}.
// Register port: cfg_we / cfg_wdata write window_size (0 acts as 1, values
//   above WINDOW_MAX act as WINDOW_MAX). Write it only while idle.
// Samples shift through a chain of WINDOW_MAX cells. After an item that yields
//   a result is taken, a token carrying running extremes walks the chain one
//   cell per cycle, and s_tready stays low until the scan is done and the
//   extremes pass to the output side, so the next item waits for the whole
//   chain; an item that yields no result leaves s_tready high.
// The output register frees the input side: a new item may enter while a
//   result waits, and a finished scan holds until the output register is
//   empty or m_tready frees it.
// Reset empties the window and sets window_size to 1; the sample chain
//   itself is not cleared, since only samples taken since the last reset or
//   restart are ever read.
// Depends on swmm_pkg and swmm_cell.
`default_nettype none

module sliding_window_min_max #(
  parameter int WINDOW_MAX = swmm_pkg::WINDOW_MAX_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        s_tvalid,
  output logic                             s_tready,
  input  wire logic [31:0]                 s_tdata,   // [31:0] sample
  input  wire logic [0:0]                  s_tuser,   // [0] restart
  output logic                             m_tvalid,
  input  wire logic                        m_tready,
  output logic [63:0]                      m_tdata,   // [31:0] window_min, [63:32] window_max
  input  wire logic                        cfg_we,
  input  wire logic [swmm_pkg::CFG_W-1:0]  cfg_wdata
);

  localparam int CW = $clog2(WINDOW_MAX + 1);
  localparam int KW = (CW > swmm_pkg::CFG_W) ? CW : swmm_pkg::CFG_W;
  localparam logic [CW-1:0] FILL_FULL = CW'(WINDOW_MAX);
  localparam logic [KW-1:0] K_MAX     = KW'(WINDOW_MAX);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_DRAIN = 3'b100
  } state_t;

  state_t                     state;
  state_t                     state_next;
  logic [swmm_pkg::CFG_W-1:0] window_size;
  logic [CW-1:0]              fill;
  logic [CW-1:0]              fill_next;
  logic [KW-1:0]              k_eff;
  logic [KW-1:0]              k;
  logic                       accept;
  logic                       fire;
  logic                       start;
  logic                       out_free;
  swmm_pkg::sample_t          sample_in;
  swmm_pkg::sample_t          pend_lo;
  swmm_pkg::sample_t          pend_hi;
  swmm_pkg::token_t           tok_head;
  swmm_pkg::sample_t          chain_s [WINDOW_MAX+1];
  swmm_pkg::token_t           chain_t [WINDOW_MAX+1];

  assign sample_in = swmm_pkg::sample_t'(s_tdata);
  assign s_tready  = state == ST_IDLE;
  assign accept    = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= swmm_pkg::CFG_W'(1);
    end else if (cfg_we) begin
      window_size <= cfg_wdata;
    end
  end

  always_comb begin
    if (window_size == '0) begin
      k_eff = KW'(1);
    end else if (KW'(window_size) > K_MAX) begin
      k_eff = K_MAX;
    end else begin
      k_eff = KW'(window_size);
    end
  end

  always_comb begin
    if (s_tuser[0]) begin
      fill_next = CW'(1);
    end else if (fill == FILL_FULL) begin
      fill_next = fill;
    end else begin
      fill_next = fill + CW'(1);
    end
  end

  assign fire = KW'(fill_next) >= k_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      fill  <= '0;
      start <= 1'b0;
    end else begin
      if (accept) begin
        fill <= fill_next;
      end
      start <= accept && fire;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      k <= k_eff;
    end
  end

  // Launch the token with identity extremes; cell 0 always folds in.
  always_comb begin
    tok_head.act = start;
    tok_head.lo  = swmm_pkg::SAMPLE_POS_MAX;
    tok_head.hi  = swmm_pkg::SAMPLE_NEG_MAX;
  end

  assign chain_s[0] = sample_in;
  assign chain_t[0] = tok_head;

  for (genvar g = 0; g < WINDOW_MAX; g++) begin : g_cell
    swmm_cell #(
      .INDEX (g),
      .KW    (KW)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .shift_en   (accept),
      .sample_in  (chain_s[g]),
      .sample_out (chain_s[g+1]),
      .k          (k),
      .tok_in     (chain_t[g]),
      .tok_out    (chain_t[g+1])
    );
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && fire) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (chain_t[WINDOW_MAX].act) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Hold the finished extremes until the output register frees up.
  always_ff @(posedge clk) begin
    if (state == ST_SCAN && chain_t[WINDOW_MAX].act) begin
      pend_lo <= chain_t[WINDOW_MAX].lo;
      pend_hi <= chain_t[WINDOW_MAX].hi;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_DRAIN && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DRAIN && out_free) begin
      m_tdata <= {pend_hi, pend_lo};
    end
  end

  a_start_follows_accept: assert property (@(posedge clk) disable iff (rst)
    start |-> $past(accept && fire))
    else $error("scan launched without a firing item");

  a_token_only_in_scan: assert property (@(posedge clk) disable iff (rst)
    chain_t[WINDOW_MAX].act |-> state == ST_SCAN)
    else $error("token reached chain end outside a scan");

  a_drain_holds: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DRAIN && m_tvalid && !m_tready) |=> state == ST_DRAIN)
    else $error("result dropped while receiver stalled");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FILL_FULL)
    else $error("fill count beyond window capacity");

endmodule

`default_nettype wire

FILE: design/swmm_cell.sv
// One chain cell: holds a sample; if in the window, folds it into the passing token.
// Depends on swmm_pkg.
`default_nettype none

module swmm_cell #(
  parameter int INDEX = 0,
  parameter int KW    = 7
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             shift_en,
  input  wire swmm_pkg::sample_t sample_in,
  output swmm_pkg::sample_t     sample_out,
  input  wire logic [KW-1:0]    k,
  input  wire swmm_pkg::token_t tok_in,
  output swmm_pkg::token_t      tok_out
);

  localparam logic [KW-1:0] IDX = KW'(INDEX);

  swmm_pkg::sample_t sample;
  swmm_pkg::token_t  tok;
  swmm_pkg::token_t  tok_next;
  logic              in_window;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      sample <= sample_in;
    end
  end

  // Only the newest k cells count; the rest pass the token on unchanged.
  assign in_window = k > IDX;

  always_comb begin
    tok_next = tok_in;
    if (in_window) begin
      tok_next.lo = (sample < tok_in.lo) ? sample : tok_in.lo;
      tok_next.hi = (sample > tok_in.hi) ? sample : tok_in.hi;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok.act <= 1'b0;
    end else begin
      tok.act <= tok_next.act;
    end
    tok.lo <= tok_next.lo;
    tok.hi <= tok_next.hi;
  end

  assign sample_out = sample;
  assign tok_out    = tok;

endmodule

`default_nettype wire

FILE: verif/sliding_window_min_max_tb.sv
// Self-checking testbench for sliding_window_min_max: stream driver, result monitor
// and a window predictor that tracks the stored samples and the window size.
// Depends on swmm_pkg and the sliding_window_min_max RTL.

module sliding_window_min_max_tb;

  localparam int WIN_DEPTH   = swmm_pkg::WINDOW_MAX_DEF;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int LONG_HOLD   = 400;

  typedef struct {
    swmm_pkg::sample_t value;
    logic              restart;
  } stim_t;

  typedef struct packed {
    swmm_pkg::sample_t lo;
    swmm_pkg::sample_t hi;
  } extremes_t;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        s_tvalid = 1'b0;
  logic                        s_tready;
  logic [31:0]                 s_tdata = '0;    // [31:0] sample
  logic [0:0]                  s_tuser = '0;    // [0] restart
  logic                        m_tvalid;
  logic                        m_tready = 1'b0;
  logic [63:0]                 m_tdata;         // [31:0] window_min, [63:32] window_max
  logic                        cfg_we = 1'b0;
  logic [swmm_pkg::CFG_W-1:0]  cfg_wdata = '0;

  // Window predictor state
  swmm_pkg::sample_t           win_buf [WIN_DEPTH];
  int                          fill_cnt = 0;
  int                          wr_slot = 0;
  logic [swmm_pkg::CFG_W-1:0]  win_size = 1;

  stim_t                       stim_q [$];
  extremes_t                   expected_extremes [$];

  int                          send_idle_pct = 0;
  int                          recv_stall_pct = 0;
  logic                        hold_req = 1'b0;
  logic                        hold_done = 1'b0;
  int                          hold_cnt = 0;
  int                          mismatch_cnt = 0;
  int                          cycle_cnt = 0;

  sliding_window_min_max uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Store the sample and, once enough are held, queue the window extremes.
  task automatic track_window(input swmm_pkg::sample_t s, input logic restart);
    int                eff;
    int                slot;
    swmm_pkg::sample_t v;
    extremes_t         res;
    if (restart) begin
      fill_cnt = 0;
      wr_slot  = 0;
    end
    win_buf[wr_slot] = s;
    wr_slot = (wr_slot + 1) % WIN_DEPTH;
    if (fill_cnt < WIN_DEPTH) fill_cnt++;
    if (win_size == 0) eff = 1;
    else if (win_size > WIN_DEPTH) eff = WIN_DEPTH;
    else eff = int'(win_size);
    if (fill_cnt >= eff) begin
      res.lo = s;
      res.hi = s;
      for (int i = 1; i < eff; i++) begin
        slot = (wr_slot + WIN_DEPTH - 1 - i) % WIN_DEPTH;
        v = win_buf[slot];
        if (v < res.lo) res.lo = v;
        if (v > res.hi) res.hi = v;
      end
      expected_extremes = {expected_extremes, res};
    end
  endtask

  // Driver: predict on each accepted item, then offer the next one or idle.
  always @(posedge clk) begin
    stim_t nxt;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) track_window(s_tdata, s_tuser[0]);
      if (!s_tvalid || s_tready) begin
        if (stim_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          nxt = stim_q.pop_front();
          s_tvalid   <= 1'b1;
          s_tdata    <= nxt.value;
          s_tuser[0] <= nxt.restart;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver ready, with one long hold-off on request.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_done <= 1'b1;
      hold_cnt  <= LONG_HOLD;
      m_tready  <= 1'b0;
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Monitor: compare each accepted result with the oldest expectation.
  always @(posedge clk) begin
    extremes_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_extremes.size() == 0) begin
        $display("%0t: unexpected result expected none got min %0d max %0d", $time,
                 $signed(m_tdata[31:0]), $signed(m_tdata[63:32]));
        mismatch_cnt++;
      end else begin
        want = expected_extremes.pop_front();
        if (m_tdata[31:0] !== want.lo) begin
          $display("%0t: window_min expected %0d got %0d", $time, want.lo,
                   $signed(m_tdata[31:0]));
          mismatch_cnt++;
        end
        if (m_tdata[63:32] !== want.hi) begin
          $display("%0t: window_max expected %0d got %0d", $time, want.hi,
                   $signed(m_tdata[63:32]));
          mismatch_cnt++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic push_item(input swmm_pkg::sample_t s, input logic restart);
    stim_t it;
    it.value   = s;
    it.restart = restart;
    stim_q = {stim_q, it};
  endtask

  // Hold until every item is taken and every result is in.
  task automatic drain();
    while (stim_q.size() != 0 || s_tvalid || expected_extremes.size() != 0)
      @(negedge clk);
  endtask

  // Drain, then let the block settle before touching the register.
  task automatic settle();
    drain();
    repeat (WIN_DEPTH + 4) @(negedge clk);
  endtask

  task automatic write_window(input logic [swmm_pkg::CFG_W-1:0] v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we   <= 1'b0;
    win_size  = v;
    @(negedge clk);
  endtask

  function automatic swmm_pkg::sample_t pick_sample();
    case ($urandom_range(0, 7))
      0:       return swmm_pkg::SAMPLE_NEG_MAX;
      1:       return swmm_pkg::SAMPLE_POS_MAX;
      2:       return swmm_pkg::sample_t'($urandom_range(0, 20)) - 10;
      default: return swmm_pkg::sample_t'($urandom);
    endcase
  endfunction

  task automatic random_phase(input logic [swmm_pkg::CFG_W-1:0] size_val, input int n,
                              input int idle_pct, input int stall_pct,
                              input int restart_permille);
    settle();
    write_window(size_val);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < n; i++)
      push_item(pick_sample(), $urandom_range(0, 999) < restart_permille);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset window size of one: every item yields a result.
    push_item(swmm_pkg::SAMPLE_NEG_MAX, 1'b0);
    push_item(swmm_pkg::SAMPLE_POS_MAX, 1'b0);
    push_item(0, 1'b0);
    push_item(-1, 1'b1);
    push_item(1, 1'b0);
    settle();
    // Grow the window mid-stream, then restart and refill.
    write_window(swmm_pkg::CFG_W'(3));
    push_item(swmm_pkg::SAMPLE_POS_MAX, 1'b0);
    push_item(swmm_pkg::SAMPLE_NEG_MAX, 1'b0);
    push_item(5, 1'b0);
    push_item(7, 1'b1);
    push_item(8, 1'b0);
    push_item(9, 1'b0);
    push_item(-9, 1'b0);
    settle();
    // Zero acts as one.
    write_window(swmm_pkg::CFG_W'(0));
    push_item(2, 1'b0);
    push_item(3, 1'b0);
    settle();
    // Oversized window clamps to the full depth; too few samples held.
    write_window(7'h7F);
    push_item(swmm_pkg::SAMPLE_NEG_MAX, 1'b0);
    push_item(swmm_pkg::SAMPLE_POS_MAX, 1'b0);
    settle();
    write_window(swmm_pkg::CFG_W'(2));
    push_item(4, 1'b0);
    push_item(-4, 1'b0);

    random_phase(swmm_pkg::CFG_W'(WIN_DEPTH), 300, 0, 0, 3);
    random_phase(swmm_pkg::CFG_W'(5), 300, 75, 0, 30);
    random_phase(7'h7F, 250, 0, 75, 2);
    random_phase(swmm_pkg::CFG_W'(0), 250, 35, 35, 50);
    hold_req = 1'b1;

    // Pause the sender halfway until every result has come back.
    random_phase(swmm_pkg::CFG_W'($urandom_range(2, WIN_DEPTH - 1)), 150, 35, 35, 10);
    drain();
    for (int i = 0; i < 150; i++)
      push_item(pick_sample(), $urandom_range(0, 999) < 10);

    random_phase(swmm_pkg::CFG_W'(WIN_DEPTH + 1), 200, 35, 35, 2);
    random_phase(swmm_pkg::CFG_W'($urandom_range(1, 20)), 100, 0, 0, 20);

    settle();
    if (mismatch_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: sim.f
design/swmm_pkg.sv
design/swmm_cell.sv
design/sliding_window_min_max.sv
verif/sliding_window_min_max_tb.sv
